FILE: src/sbvt_pkg.sv
// Package for the segment block validity tracker.
// Holds request/status/register codes, field widths and the structs shared
// by the config, engine and top-level modules. No dependencies.
package sbvt_pkg;

    // Default depth of the slot valid map
    localparam int SEG_DEPTH_DEF = 1024;

    // Field widths fixed by the interface
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 32;
    localparam int OFF_W  = 10;
    localparam int CNT_W  = 11;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 1;

    localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
    localparam logic [ADDR_W-1:0] LBA_INVALID = '1;
    localparam logic [CNT_W-1:0]  SEG_SIZE_RST = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INVAL  = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        CFG_SEG_SIZE = 1'b0,
        CFG_BASE     = 1'b1
    } t_cfg_idx;

    // Live configuration as seen by the engine
    typedef struct packed {
        logic [CNT_W-1:0]  eff_size;
        logic [ADDR_W-1:0] base;
    } t_cfg;

    // Map write-back from the engine
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] slot;
        logic             data;
    } t_wr;

    // One result beat plus updated pointers
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] paddr;
        logic              valid;
        logic [CNT_W-1:0]  inv_cnt;
        logic [CNT_W-1:0]  next_slot;
        logic              full;
    } t_result;

endpackage

FILE: src/sbvt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module sbvt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sbvt_cfg.sv
// Configuration registers: segment size and base block address.
// Clamps the size to the map depth. Depends on sbvt_pkg.
module sbvt_cfg #(
    parameter int SEG_DEPTH = sbvt_pkg::SEG_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sbvt_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [sbvt_pkg::ADDR_W-1:0] i_cfg_data,
    output sbvt_pkg::t_cfg              o_cfg
);
    import sbvt_pkg::*;

    localparam logic [16:0] DEPTH_W = 17'(SEG_DEPTH);

    logic [CNT_W-1:0]  r_seg_size;
    logic [ADDR_W-1:0] r_base;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size <= SEG_SIZE_RST;
            r_base     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SEG_SIZE: r_seg_size <= i_cfg_data[CNT_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Effective size: never beyond the map depth
    always_comb begin
        o_cfg.base     = r_base;
        o_cfg.eff_size = ({6'b0, r_seg_size} > DEPTH_W) ? DEPTH_W[CNT_W-1:0] : r_seg_size;
    end

endmodule

FILE: src/sbvt_engine.sv
// Request engine: modify step of the valid-map read-modify-write.
// Computes the result beat, pointer updates and map write. Depends on sbvt_pkg.
module sbvt_engine (
    input  sbvt_pkg::t_cfg              i_cfg,
    input  logic [sbvt_pkg::REQ_W-1:0]  i_req,
    input  logic [sbvt_pkg::ADDR_W-1:0] i_lba,
    input  logic [sbvt_pkg::OFF_W-1:0]  i_off,
    input  logic                        i_map_bit,
    input  logic [sbvt_pkg::CNT_W-1:0]  i_next_slot,
    input  logic [sbvt_pkg::CNT_W-1:0]  i_inv_cnt,
    output sbvt_pkg::t_result           o_res,
    output sbvt_pkg::t_wr               o_wr
);
    import sbvt_pkg::*;

    logic             w_full_now;
    logic             w_in_range;
    logic             w_slot_valid;
    logic [CNT_W-1:0] w_next;

    // Slots at or past the append pointer were never written since reset
    assign w_full_now   = (i_next_slot >= i_cfg.eff_size);
    assign w_in_range   = ({1'b0, i_off} < i_cfg.eff_size);
    assign w_slot_valid = ({1'b0, i_off} < i_next_slot) && i_map_bit;

    always_comb begin
        w_next          = i_next_slot;
        o_res.status    = ST_OK;
        o_res.paddr     = '0;
        o_res.valid     = 1'b0;
        o_res.inv_cnt   = i_inv_cnt;
        o_wr.we         = 1'b0;
        o_wr.slot       = i_next_slot;
        o_wr.data       = 1'b0;

        unique case (t_req'(i_req))
            REQ_APPEND: begin
                if (w_full_now) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.paddr = i_cfg.base + {21'b0, i_next_slot};
                    o_res.valid = (i_lba != LBA_INVALID);
                    o_wr.we     = 1'b1;
                    o_wr.data   = (i_lba != LBA_INVALID);
                    w_next      = i_next_slot + 1'b1;
                end
            end
            REQ_INVAL: begin
                if (!w_in_range) begin
                    o_res.status = ST_RANGE;
                end else if (w_slot_valid) begin
                    o_wr.we   = 1'b1;
                    o_wr.slot = {1'b0, i_off};
                    if (i_inv_cnt != CNT_MAX) begin
                        o_res.inv_cnt = i_inv_cnt + 1'b1;
                    end
                end
            end
            REQ_QUERY: begin
                if (!w_in_range) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_res.valid = w_slot_valid;
                end
            end
            default: ;
        endcase

        o_res.next_slot = w_next;
        o_res.full      = (w_next >= i_cfg.eff_size);
    end

endmodule

FILE: src/segment_block_validity_tracker_core.sv
// Flow: an accepted request is held in stage 1 while its map bit is read; that bit
// feeds the update, whose result is then registered in the output register.
// Throughput: one request per cycle while the output is not stalled; the single-write
// map RAM with write-to-read forwarding sets that rate. Output stalls back up to the input.
// Reset: synchronous, active low; append pointer and invalid count cleared, size 1024,
// base 0. The map needs no clearing pass: slots past the append pointer read invalid.
module segment_block_validity_tracker_core #(
    parameter int SEG_DEPTH = sbvt_pkg::SEG_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic [sbvt_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [sbvt_pkg::ADDR_W-1:0] i_cfg_data,
    // Request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sbvt_pkg::REQ_W-1:0]  i_req_type,
    input  logic [sbvt_pkg::ADDR_W-1:0] i_logical_addr,
    input  logic [sbvt_pkg::OFF_W-1:0]  i_slot_offset,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sbvt_pkg::ST_W-1:0]   o_status,
    output logic [sbvt_pkg::ADDR_W-1:0] o_physical_addr,
    output logic                        o_block_valid,
    output logic [sbvt_pkg::CNT_W-1:0]  o_invalid_count,
    output logic [sbvt_pkg::CNT_W-1:0]  o_append_offset,
    output logic                        o_is_full
);
    import sbvt_pkg::*;

    localparam int AW = $clog2(SEG_DEPTH);

    t_cfg    w_cfg;
    t_result w_res;
    t_wr     w_wr;

    logic              w_in_fire;
    logic              w_s1_fire;
    logic              w_ram_we;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic [31:0]       w_raddr_ext;
    logic [31:0]       w_waddr_ext;
    logic              w_ram_rdata;
    logic              w_map_bit;

    // Stage 1: request waiting on its map read
    logic              r_s1_valid;
    logic [REQ_W-1:0]  r_s1_req;
    logic [ADDR_W-1:0] r_s1_lba;
    logic [OFF_W-1:0]  r_s1_off;
    logic              r_s1_fwd;
    logic              r_s1_fwd_val;

    logic [CNT_W-1:0]  r_next_slot;
    logic [CNT_W-1:0]  r_inv_cnt;

    // Output register
    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [ADDR_W-1:0] r_paddr;
    logic              r_bvalid;
    logic [CNT_W-1:0]  r_out_inv;
    logic [CNT_W-1:0]  r_out_next;
    logic              r_out_full;

    sbvt_cfg #(.SEG_DEPTH(SEG_DEPTH)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Handshake
    assign w_s1_fire  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_fire;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // Map addresses
    assign w_raddr_ext = {22'b0, i_slot_offset};
    assign w_waddr_ext = {21'b0, w_wr.slot};
    assign w_raddr     = w_raddr_ext[AW-1:0];
    assign w_waddr     = w_waddr_ext[AW-1:0];
    assign w_ram_we    = w_s1_fire && w_wr.we;

    sbvt_ram #(.WIDTH(1), .DEPTH(SEG_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.data),
        .i_re    (w_in_fire),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Forwarded value wins over the RAM's read-first data
    assign w_map_bit = r_s1_fwd ? r_s1_fwd_val : w_ram_rdata;

    sbvt_engine u_engine (
        .i_cfg       (w_cfg),
        .i_req       (r_s1_req),
        .i_lba       (r_s1_lba),
        .i_off       (r_s1_off),
        .i_map_bit   (w_map_bit),
        .i_next_slot (r_next_slot),
        .i_inv_cnt   (r_inv_cnt),
        .o_res       (w_res),
        .o_wr        (w_wr)
    );

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload and forwarding capture
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_req     <= i_req_type;
            r_s1_lba     <= i_logical_addr;
            r_s1_off     <= i_slot_offset;
            r_s1_fwd     <= w_ram_we && (w_waddr == w_raddr);
            r_s1_fwd_val <= w_wr.data;
        end
    end

    // Segment pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= '0;
            r_inv_cnt   <= '0;
        end else if (w_s1_fire) begin
            r_next_slot <= w_res.next_slot;
            r_inv_cnt   <= w_res.inv_cnt;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_status   <= w_res.status;
            r_paddr    <= w_res.paddr;
            r_bvalid   <= w_res.valid;
            r_out_inv  <= w_res.inv_cnt;
            r_out_next <= w_res.next_slot;
            r_out_full <= w_res.full;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_physical_addr = r_paddr;
    assign o_block_valid   = r_bvalid;
    assign o_invalid_count = r_out_inv;
    assign o_append_offset = r_out_next;
    assign o_is_full       = r_out_full;

    // Each invalidation needs a slot appended earlier
    a_inv_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inv_cnt <= r_next_slot)
        else $error("invalid count above append pointer");

    // Input stalls only behind a held stage-1 request
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked request");

    // Pointer moves only on a completing request, by at most one
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_fire |=> (r_next_slot == $past(r_next_slot)))
        else $error("append pointer moved without a request");

    // A result beat leaves the output register only when taken or replaced
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_paddr)))
        else $error("stalled result lost");

endmodule
